// ===== rtl/ght_pkg.sv =====
// Package for the generational handle table: field widths, operation codes
// and the control struct passed between the check stage and the top level.
// No dependencies.
package ght_pkg;

  localparam int SLOT_COUNT_DEF = 64;

  localparam int OP_W   = 2;
  localparam int SLOT_W = 7;
  localparam int GEN_W  = 32;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd2;

  // Outcome of one request as decided in the second stage.
  typedef struct packed {
    logic ok;
    logic set_occ;
    logic clr_occ;
    logic write_gen;
  } ght_ctl_t;

endpackage

// ===== rtl/ght_if.sv =====
// Request and response channel interfaces of the generational handle table.
// Depends on ght_pkg.
interface ght_req_if;
  import ght_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SLOT_W-1:0] handle_slot;
  logic [GEN_W-1:0]  handle_generation;

  modport source(output valid, operation, handle_slot, handle_generation, input ready);
  modport sink(input valid, operation, handle_slot, handle_generation, output ready);
endinterface

interface ght_rsp_if;
  import ght_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [SLOT_W-1:0] result_slot;
  logic [GEN_W-1:0]  result_generation;

  modport source(output valid, ok, result_slot, result_generation, input ready);
  modport sink(input valid, ok, result_slot, result_generation, output ready);
endinterface

// ===== rtl/ght_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ght_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ght_alloc_pick.sv =====
// Priority encoder that finds the lowest free slot for an allocation.
// Depends on nothing but its parameters.
module ght_alloc_pick #(
  parameter int SLOT_COUNT = 64,
  parameter int IDX_W      = 6
) (
  input  logic [SLOT_COUNT-1:0] occ,
  output logic                  found,
  output logic [IDX_W-1:0]      idx
);

  always_comb begin
    idx = '0;
    // Scan from the top so that the lowest free slot is the last one taken.
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!occ[i]) begin
        idx = IDX_W'(i);
      end
    end
    found = ~&occ;
  end

endmodule

// ===== rtl/ght_check.sv =====
// Second-stage decision: validates a handle or completes an allocation
// from the stored generation. Depends on ght_pkg.
module ght_check (
  input  logic [ght_pkg::OP_W-1:0]  op,
  input  logic                      in_range,
  input  logic                      found,
  input  logic                      occ_bit,
  input  logic [ght_pkg::GEN_W-1:0] cur_gen,
  input  logic [ght_pkg::GEN_W-1:0] hgen,
  output ght_pkg::ght_ctl_t         ctl,
  output logic [ght_pkg::GEN_W-1:0] res_gen
);
  import ght_pkg::*;

  logic match;

  assign match = in_range && occ_bit && (cur_gen == hgen);

  always_comb begin
    ctl     = '0;
    res_gen = cur_gen;
    case (op)
      OP_ALLOC: begin
        res_gen       = cur_gen + GEN_W'(1);
        ctl.ok        = found;
        ctl.set_occ   = found;
        ctl.write_gen = found;
      end
      OP_LOOKUP: begin
        ctl.ok = match;
      end
      OP_FREE: begin
        ctl.ok      = match;
        ctl.clr_occ = match;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

// ===== rtl/generational_handle_table_core.sv =====
// Generational handle table: top level with the request pipeline, the
// occupancy flags and the generation RAM. Depends on ght_pkg, ght_if,
// ght_ram, ght_alloc_pick and ght_check.
//
// Usage: requests arrive on req (operation, handle_slot, handle_generation)
// and each produces exactly one response on rsp (ok, result_slot,
// result_generation). Allocate takes the lowest free slot and returns its
// 1-based number and its incremented generation; look up and free return
// the handle back when it names an occupied slot of matching generation.
// Any failure answers ok 0 with zero slot and generation.
//
// Timing: an accepted request passes through the input register, the check
// stage and the output register, which presents it on rsp. A new request is
// taken every cycle while rsp is not stalled; the single generation RAM read
// port serves one slot per request, and back-to-back requests on the same
// slot are forwarded.
//
// Reset clears all occupancy flags and marks every generation as never
// written, which reads as zero, so the table is usable as soon as reset is
// released, with no clearing pass. When the receiver holds rsp.ready low
// with a response waiting, the whole pipeline holds and req.ready drops.
module generational_handle_table_core #(
  parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  ght_req_if.sink  req,
  ght_rsp_if.source rsp
);
  import ght_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int AW    = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;

  // The pipeline moves as a whole whenever the output register can load.
  logic adv;

  // Input register.
  logic              s1_valid;
  logic [OP_W-1:0]   s1_op;
  logic [SLOT_W-1:0] s1_slot;
  logic [GEN_W-1:0]  s1_gen;

  // Check stage.
  logic              s2_valid;
  logic [OP_W-1:0]   s2_op;
  logic [IDX_W-1:0]  s2_idx;
  logic              s2_in_range;
  logic              s2_found;
  logic              s2_occ;
  logic [GEN_W-1:0]  s2_hgen;
  logic              s2_fwd;
  logic [GEN_W-1:0]  s2_fwd_data;

  // Table state.
  logic [SLOT_COUNT-1:0] occ;
  logic [SLOT_COUNT-1:0] written;

  // Output register.
  logic              out_valid;
  logic              out_ok;
  logic [SLOT_W-1:0] out_slot;
  logic [GEN_W-1:0]  out_gen;

  logic [SLOT_COUNT-1:0] occ_eff;
  logic                  pick_found;
  logic [IDX_W-1:0]      pick_idx;
  logic [AW-1:0]         slot_m1;
  logic                  s1_in_range;
  logic [IDX_W-1:0]      s1_idx;
  logic [GEN_W-1:0]      ram_rdata;
  logic [GEN_W-1:0]      cur_gen;
  logic [GEN_W-1:0]      res_gen;
  ght_ctl_t              ctl;
  logic                  gen_we;
  logic [SLOT_W-1:0]     res_slot;

  assign adv       = !out_valid || rsp.ready;
  assign req.ready = adv;

  // Occupancy as it will be once the request in the check stage retires,
  // so that the request behind it sees its effect.
  always_comb begin
    occ_eff = occ;
    if (s2_valid && ctl.set_occ) begin
      occ_eff[s2_idx] = 1'b1;
    end
    if (s2_valid && ctl.clr_occ) begin
      occ_eff[s2_idx] = 1'b0;
    end
  end

  ght_alloc_pick #(
    .SLOT_COUNT(SLOT_COUNT),
    .IDX_W     (IDX_W)
  ) u_pick (
    .occ  (occ_eff),
    .found(pick_found),
    .idx  (pick_idx)
  );

  // Handle decode: slot numbers are 1-based, zero and values past the
  // table size never match.
  assign slot_m1     = AW'(s1_slot) - AW'(1);
  assign s1_in_range = (s1_slot != '0) && (32'(s1_slot) <= 32'(SLOT_COUNT));
  assign s1_idx      = (s1_op == OP_ALLOC) ? pick_idx : slot_m1[IDX_W-1:0];

  assign gen_we = adv && s2_valid && ctl.write_gen;

  ght_ram #(
    .WIDTH(GEN_W),
    .DEPTH(SLOT_COUNT)
  ) u_gen_ram (
    .clk  (clk),
    .we   (gen_we),
    .waddr(s2_idx),
    .wdata(res_gen),
    .re   (adv),
    .raddr(s1_idx),
    .rdata(ram_rdata)
  );

  // A slot never written reads as zero; a slot written by the request just
  // ahead takes the forwarded value instead of the stale RAM word.
  assign cur_gen = s2_fwd ? s2_fwd_data : ram_rdata;

  ght_check u_check (
    .op      (s2_op),
    .in_range(s2_in_range),
    .found   (s2_found),
    .occ_bit (s2_occ),
    .cur_gen (cur_gen),
    .hgen    (s2_hgen),
    .ctl     (ctl),
    .res_gen (res_gen)
  );

  assign res_slot = SLOT_W'(AW'(s2_idx) + AW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      occ       <= '0;
      written   <= '0;
    end else if (adv) begin
      s1_valid  <= req.valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
      if (s2_valid && ctl.set_occ) begin
        occ[s2_idx] <= 1'b1;
      end
      if (s2_valid && ctl.clr_occ) begin
        occ[s2_idx] <= 1'b0;
      end
      if (gen_we) begin
        written[s2_idx] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op   <= req.operation;
      s1_slot <= req.handle_slot;
      s1_gen  <= req.handle_generation;

      s2_op       <= s1_op;
      s2_idx      <= s1_idx;
      s2_in_range <= s1_in_range;
      s2_found    <= pick_found;
      s2_occ      <= occ_eff[s1_idx];
      s2_hgen     <= s1_gen;
      if (gen_we && (s2_idx == s1_idx)) begin
        s2_fwd      <= 1'b1;
        s2_fwd_data <= res_gen;
      end else begin
        s2_fwd      <= !written[s1_idx];
        s2_fwd_data <= '0;
      end

      out_ok   <= ctl.ok;
      out_slot <= ctl.ok ? res_slot : '0;
      out_gen  <= ctl.ok ? res_gen : '0;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.ok                = out_ok;
  assign rsp.result_slot       = out_slot;
  assign rsp.result_generation = out_gen;

endmodule

// ===== verif/ght_tb_pkg.sv =====
// Scoreboard for the generational handle table testbench: a table predictor
// and the queue of expected responses it fills. Depends on ght_pkg.
package ght_tb_pkg;
  import ght_pkg::*;

  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
  } handle_resp_t;

  class handle_scoreboard;
    bit             occupied   [SLOT_COUNT_DEF];
    bit [GEN_W-1:0] generation [SLOT_COUNT_DEF];
    handle_resp_t   expected_responses [$];
    int unsigned    mismatches;

    function new();
      for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
        occupied[i]   = 1'b0;
        generation[i] = '0;
      end
      mismatches = 0;
    endfunction

    // Applies one request to the shadow table and returns its response.
    function handle_resp_t predict_response(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                            logic [GEN_W-1:0] gen);
      handle_resp_t r;
      bit           found;
      int           idx;
      r     = '0;
      found = 1'b0;
      case (op)
        OP_ALLOC: begin
          for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
            if (!found && !occupied[i]) begin
              found         = 1'b1;
              generation[i] = generation[i] + 1'b1;
              occupied[i]   = 1'b1;
              r.ok          = 1'b1;
              r.slot        = SLOT_W'(i + 1);
              r.gen         = generation[i];
            end
          end
        end
        OP_LOOKUP, OP_FREE: begin
          if (slot >= 1 && slot <= SLOT_COUNT_DEF) begin
            idx = int'(slot) - 1;
            if (occupied[idx] && generation[idx] == gen) begin
              r.ok   = 1'b1;
              r.slot = slot;
              r.gen  = generation[idx];
              if (op == OP_FREE) occupied[idx] = 1'b0;
            end
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                               logic [GEN_W-1:0] gen);
      expected_responses.push_back(predict_response(op, slot, gen));
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_response(logic ok, logic [SLOT_W-1:0] slot, logic [GEN_W-1:0] gen);
      handle_resp_t exp_r;
      if (expected_responses.size() == 0) begin
        report($sformatf("response ok=%b slot=%0d gen=%h with no request outstanding",
                         ok, slot, gen));
      end else begin
        exp_r = expected_responses.pop_front();
        if (ok !== exp_r.ok)
          report($sformatf("ok is %b, expected %b", ok, exp_r.ok));
        if (slot !== exp_r.slot)
          report($sformatf("result_slot is %0d, expected %0d", slot, exp_r.slot));
        if (gen !== exp_r.gen)
          report($sformatf("result_generation is %h, expected %h", gen, exp_r.gen));
      end
    endtask

    function int pending();
      return expected_responses.size();
    endfunction

    // Random occupied slot index, or -1 when the table is empty.
    function int pick_live();
      int live [$];
      for (int i = 0; i < SLOT_COUNT_DEF; i++) if (occupied[i]) live.push_back(i);
      if (live.size() == 0) return -1;
      return live[$urandom_range(live.size() - 1)];
    endfunction

    // Random freed slot that was handed out before, or -1 when there is none.
    function int pick_retired();
      int gone [$];
      for (int i = 0; i < SLOT_COUNT_DEF; i++)
        if (!occupied[i] && generation[i] != 0) gone.push_back(i);
      if (gone.size() == 0) return -1;
      return gone[$urandom_range(gone.size() - 1)];
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
// Top-level testbench of generational_handle_table_core: drives requests,
// stalls responses and checks every response against the scoreboard.
// Depends on ght_pkg, ght_if and ght_tb_pkg.
module tb_top;
  import ght_pkg::*;
  import ght_tb_pkg::*;

  // The run is far shorter than this even with the heaviest idling; it only
  // guards against a block that stops answering.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int ITEMS_PER_RUN = 200;

  logic clk;
  logic rst;

  ght_req_if req_bus();
  ght_rsp_if rsp_bus();

  generational_handle_table_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  handle_scoreboard sb = new();

  int unsigned cycle_count   = 0;
  int          idle_pct      = 0;
  int          stall_pct     = 0;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a run that never drains is a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Monitor. Both channels are sampled at the rising edge, where the values
  // driven at the previous falling edge are stable. A request can never be
  // answered in the edge that accepts it, so the order of the two checks
  // does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_bus.valid && req_bus.ready)
        sb.note_request(req_bus.operation, req_bus.handle_slot, req_bus.handle_generation);
      if (rsp_bus.valid && rsp_bus.ready)
        sb.check_response(rsp_bus.ok, rsp_bus.result_slot, rsp_bus.result_generation);
    end
  end

  // Response side. The main process asks for a long hold-off by bumping
  // hold_requests; this process alone counts the hold-off down, so every
  // counter has a single writer. Outside a hold-off ready is random with the
  // stall rate of the current phase.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_bus.ready = 1'b0;
      hold_left--;
    end else if (hold_requests != hold_served) begin
      hold_served   = hold_requests;
      hold_left     = HOLD_CYCLES - 1;
      rsp_bus.ready = 1'b0;
    end else begin
      rsp_bus.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one request, with random idle cycles in front of it, and returns
  // at the rising edge that accepts it. Valid stays high from one request to
  // the next when no gap is drawn.
  task automatic send(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                      input logic [GEN_W-1:0] gen);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.valid             = 1'b1;
    req_bus.operation         = op;
    req_bus.handle_slot       = slot;
    req_bus.handle_generation = gen;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // Stops offering and waits until every outstanding request is answered,
  // then waits on with the pipeline empty before returning.
  task automatic drain();
    @(negedge clk);
    req_bus.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One random request. Most lookups and frees use handles that are live in
  // the table so that they actually hit; the rest are allocations, stale
  // handles and plain noise over the whole field ranges.
  task automatic send_random(input int alloc_pct);
    int               pick;
    int               idx;
    logic [OP_W-1:0]  op;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0] gen;
    pick = $urandom_range(99);
    op   = OP_ALLOC;
    slot = SLOT_W'($urandom_range(127));
    gen  = GEN_W'($urandom);
    if (pick >= alloc_pct) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        // Live handle, looked up or freed.
        op  = (pick < 35) ? OP_LOOKUP : OP_FREE;
        idx = sb.pick_live();
        if (idx >= 0) begin
          slot = SLOT_W'(idx + 1);
          gen  = sb.generation[idx];
        end
      end else if (pick < 80) begin
        // Stale handle: either a freed handle or a live slot with one
        // generation bit flipped.
        op  = $urandom_range(1) ? OP_LOOKUP : OP_FREE;
        idx = $urandom_range(1) ? sb.pick_retired() : sb.pick_live();
        if (idx >= 0) begin
          slot = SLOT_W'(idx + 1);
          gen  = sb.generation[idx];
          if (sb.occupied[idx]) gen = gen ^ (GEN_W'(1) << $urandom_range(GEN_W - 1));
        end
      end else begin
        // Noise over every operation code, including the undefined one.
        op = OP_W'($urandom_range(3));
      end
    end
    send(op, slot, gen);
  endtask

  initial begin
    int n;
    rst                       = 1'b1;
    req_bus.valid             = 1'b0;
    req_bus.operation         = OP_ALLOC;
    req_bus.handle_slot       = '0;
    req_bus.handle_generation = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: an allocation, lookups of a valid, a stale, the empty
    // and out-of-range handles, the undefined operation, a double free, a
    // reallocation that bumps the generation, and back-to-back requests on
    // the same slot that need forwarding inside the block.
    send(OP_ALLOC,  7'd0,   32'h0000_0000);
    send(OP_LOOKUP, 7'd1,   32'h0000_0001);
    send(OP_LOOKUP, 7'd1,   32'h0000_0000);
    send(OP_LOOKUP, 7'd0,   32'h0000_0000);
    send(OP_LOOKUP, 7'd65,  32'h0000_0001);
    send(OP_LOOKUP, 7'd127, 32'hffff_ffff);
    send(OP_LOOKUP, 7'd64,  32'h0000_0000);
    send(OP_ALLOC,  7'd127, 32'hffff_ffff);
    send(OP_UNDEF,  7'd1,   32'h0000_0001);
    send(OP_UNDEF,  7'd127, 32'hffff_ffff);
    send(OP_FREE,   7'd1,   32'h0000_0001);
    send(OP_LOOKUP, 7'd1,   32'h0000_0001);
    send(OP_FREE,   7'd1,   32'h0000_0001);
    send(OP_ALLOC,  7'd0,   32'h0000_0000);
    send(OP_LOOKUP, 7'd1,   32'h0000_0002);
    send(OP_FREE,   7'd1,   32'h0000_0001);
    send(OP_FREE,   7'd0,   32'h0000_0000);
    send(OP_FREE,   7'd65,  32'h0000_0000);
    send(OP_FREE,   7'd2,   32'h8000_0001);
    send(OP_FREE,   7'd2,   32'h0000_0001);
    send(OP_ALLOC,  7'd0,   32'h0000_0000);
    send(OP_FREE,   7'd2,   32'h0000_0002);
    send(OP_ALLOC,  7'd0,   32'h0000_0000);
    send(OP_LOOKUP, 7'd2,   32'h0000_0003);
    drain();

    // Random part in eight phases. The first four lean on allocation so the
    // table fills up and allocations start to fail; the last four lean on
    // freeing so it empties again. Each group of four walks through no
    // idling, sender gaps, receiver stalls and both at once, and each phase
    // ends with the sender pausing until every response has come back.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 50;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 50;
        end
        default: begin
          idle_pct  = 31;
          stall_pct = 31;
        end
      endcase
      for (n = 0; n < ITEMS_PER_RUN; n++) begin
        // Long hold-off on the response side while requests keep coming, so
        // the pipeline fills and the block has to drop req.ready.
        if (phase == 0 && n == 40) hold_requests++;
        send_random((phase < 4) ? 45 : 15);
      end
      drain();
    end

    if (sb.pending() != 0)
      sb.report($sformatf("%0d responses never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
